### hw/rtl/itp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg: shared types and helpers for the infix-to-postfix converter
// Request and result structs, command classification and operator precedence.
// ----------------------------------------------------------------------------
package itp_pkg;

  // Characters with a special role
  localparam logic [7:0] CH_CARET = 8'h5E;  // '^'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Error flag bit positions
  localparam int unsigned ERR_OVERFLOW_BIT  = 0;
  localparam int unsigned ERR_UNMATCHED_BIT = 1;

  typedef struct packed {
    logic [7:0] symbol;
    logic       flush;
  } sym_in_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       is_terminator;
    logic [1:0] error_code;
    logic       last;
  } sym_out_t;

  typedef enum logic [2:0] {
    KIND_OPERAND,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_OPER,
    KIND_FLUSH
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] sym;
    logic [1:0] prec;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_e;

  function automatic logic [1:0] prec_of(logic [7:0] c);
    logic [1:0] p;
    if (c == CH_CARET) begin
      p = 2'd3;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      p = 2'd2;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      p = 2'd1;
    end else begin
      p = 2'd0;
    end
    return p;
  endfunction

  function automatic logic is_operand(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic cmd_t classify(sym_in_t req);
    cmd_t cmd;
    cmd.sym  = req.symbol;
    cmd.prec = prec_of(req.symbol);
    if (req.flush) begin
      cmd.kind = KIND_FLUSH;
    end else if (is_operand(req.symbol)) begin
      cmd.kind = KIND_OPERAND;
    end else if (req.symbol == CH_OPEN) begin
      cmd.kind = KIND_OPEN;
    end else if (req.symbol == CH_CLOSE) begin
      cmd.kind = KIND_CLOSE;
    end else begin
      cmd.kind = KIND_OPER;
    end
    return cmd;
  endfunction

  function automatic sym_out_t make_out(logic [7:0] sym, logic term,
                                        logic [1:0] err, logic last);
    sym_out_t r;
    r.out_symbol    = sym;
    r.is_terminator = term;
    r.error_code    = err;
    r.last          = last;
    return r;
  endfunction

endpackage

### hw/rtl/itp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_front: request intake
// Register one request per cycle unless stalled, classified into a stack command.
// ----------------------------------------------------------------------------
module itp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  itp_pkg::sym_in_t in_data_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output itp_pkg::cmd_t    cmd_o
);

  logic          valid_q, valid_d;
  itp_pkg::cmd_t cmd_q;
  logic          accept;

  // Stall only while the held command cannot move into the queue
  assign in_stall_o = valid_q && !cmd_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= itp_pkg::classify(in_data_i);
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

### hw/rtl/itp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_queue: two-entry command queue
// Decouple the intake from the stack engine so each side stalls on its own.
// ----------------------------------------------------------------------------
module itp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  itp_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output itp_pkg::cmd_t rd_data_o
);

  itp_pkg::cmd_t entry_q [2];
  logic          wp_q, wp_d;
  logic          rp_q, rp_d;
  logic [1:0]    fill_q, fill_d;
  logic          push, pop;

  assign wr_ready_o = (fill_q != 2'd2);
  assign rd_valid_o = (fill_q != 2'd0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = entry_q[rp_q];

  always_comb begin
    wp_d   = push ? ~wp_q : wp_q;
    rp_d   = pop ? ~rp_q : rp_q;
    fill_d = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wp_q] <= wr_data_i;
    end
  end

endmodule

### hw/rtl/itp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_back: operator stack engine
// Execute one stack step per cycle while the output is free; drive the output register.
// ----------------------------------------------------------------------------
module itp_back #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  itp_pkg::cmd_t     cmd_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output itp_pkg::sym_out_t out_data_o
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [CntW-1:0] CntTwo  = CntW'(2);

  // Full copy of the stack; top_q mirrors entry count-1, sub_q entry count-2
  logic [7:0]              stack_mem [STACK_DEPTH];
  logic [7:0]              sub_q;
  logic [7:0]              top_q, top_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [1:0]              err_q, err_d;
  itp_pkg::back_state_e    st_q, st_d;
  itp_pkg::cmd_t           cur_q, cur_d;
  logic                    out_valid_q, out_valid_d;
  itp_pkg::sym_out_t       out_q, out_d;
  logic                    out_free;
  logic                    done;
  logic                    do_push, do_pop;
  logic                    mem_we;
  logic [AddrW-1:0]        wr_addr, rd_addr;
  logic                    pop_more;

  assign out_free = !out_valid_q || !out_stall_i;
  assign wr_addr  = count_q[AddrW-1:0];

  always_comb begin
    st_d        = st_q;
    cur_d       = cur_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cmd_ready_o = 1'b0;
    done        = 1'b0;
    do_push     = 1'b0;
    do_pop      = 1'b0;
    pop_more    = 1'b0;

    case (st_q)
      itp_pkg::BK_IDLE: begin
        done = 1'b1;
      end
      itp_pkg::BK_EXEC: begin
        case (cur_q.kind)
          itp_pkg::KIND_OPERAND: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_d = itp_pkg::make_out(cur_q.sym, 1'b0, 2'd0, 1'b1);
              done  = 1'b1;
            end
          end
          itp_pkg::KIND_OPEN: begin
            do_push = 1'b1;
            done    = 1'b1;
          end
          itp_pkg::KIND_CLOSE: begin
            if (count_q == '0) begin
              // unmatched close paren: flag and stop
              err_d[itp_pkg::ERR_UNMATCHED_BIT] = 1'b1;
              done = 1'b1;
            end else if (top_q == itp_pkg::CH_OPEN) begin
              // drop the matching open paren silently
              do_pop = 1'b1;
              done   = 1'b1;
            end else if (out_free) begin
              // last emit when the next top is '(' or the stack runs dry
              pop_more    = (count_q != CntOne) && (sub_q != itp_pkg::CH_OPEN);
              out_valid_d = 1'b1;
              out_d  = itp_pkg::make_out(top_q, 1'b0, 2'd0, !pop_more);
              do_pop = 1'b1;
            end
          end
          itp_pkg::KIND_OPER: begin
            if (count_q != '0 && itp_pkg::prec_of(top_q) >= cur_q.prec) begin
              if (out_free) begin
                pop_more    = (count_q != CntOne) &&
                              (itp_pkg::prec_of(sub_q) >= cur_q.prec);
                out_valid_d = 1'b1;
                out_d  = itp_pkg::make_out(top_q, 1'b0, 2'd0, !pop_more);
                do_pop = 1'b1;
              end
            end else begin
              do_push = 1'b1;
              done    = 1'b1;
            end
          end
          itp_pkg::KIND_FLUSH: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              if (count_q != '0) begin
                out_d  = itp_pkg::make_out(top_q, 1'b0, 2'd0, 1'b0);
                do_pop = 1'b1;
              end else begin
                out_d = itp_pkg::make_out(itp_pkg::CH_NUL, 1'b1, err_q, 1'b1);
                err_d = 2'd0;
                done  = 1'b1;
              end
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      default: begin
        st_d = itp_pkg::BK_IDLE;
      end
    endcase

    // Chain straight into the next queued command
    if (done) begin
      if (cmd_valid_i) begin
        cmd_ready_o = 1'b1;
        cur_d       = cmd_i;
        st_d        = itp_pkg::BK_EXEC;
      end else begin
        st_d = itp_pkg::BK_IDLE;
      end
    end
  end

  // Stack pointer, top cache and memory write
  always_comb begin
    top_d   = top_q;
    count_d = count_q;
    mem_we  = 1'b0;
    if (do_push) begin
      if (count_q < CntFull) begin
        mem_we  = 1'b1;
        top_d   = cur_q.sym;
        count_d = count_q + CntOne;
      end
    end else if (do_pop) begin
      top_d   = sub_q;
      count_d = count_q - CntOne;
    end
    if (count_d >= CntTwo) begin
      rd_addr = AddrW'(count_d - CntTwo);
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= itp_pkg::BK_IDLE;
      count_q     <= '0;
      err_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      count_q     <= count_d;
      err_q       <= (do_push && count_q == CntFull) ?
                     (err_d | 2'(1 << itp_pkg::ERR_OVERFLOW_BIT)) : err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    top_q <= top_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= cur_q.sym;
    end
    sub_q <= stack_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("stack count above depth");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (count_q == $past(count_q) || count_q == $past(count_q) + CntOne ||
         count_q == $past(count_q) - CntOne))
    else $error("stack count moved by more than one");

  a_term_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.is_terminator |-> out_q.last && out_q.out_symbol == 8'd0)
    else $error("terminator without last or with nonzero symbol");

  a_plain_noerr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.is_terminator |-> out_q.error_code == 2'd0)
    else $error("error code on a non-terminator result");

  a_term_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == itp_pkg::BK_EXEC && cur_q.kind == itp_pkg::KIND_FLUSH &&
    count_q == '0 && out_free |=> err_q == 2'd0 && count_q == '0)
    else $error("flags not cleared after terminator");

endmodule

### hw/rtl/infix_to_postfix_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core: shunting-yard infix to postfix converter
// Intake, two-entry command queue and operator stack engine.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one ASCII character per request on the input channel (in_valid_i /
//   in_stall_o, payload in_data_i). Set flush to end an expression: the
//   stack is emptied and a terminator carrying the error code follows.
//   Results leave on the output channel (out_valid_o / out_stall_i,
//   payload out_data_o); last marks the final result of each request.
// Path: with nothing queued ahead of it, an operand request passes the intake
//   register, a queue entry, the engine command register and the output register.
// Throughput: the stack engine does one step per cycle while the output is
//   free. An operand, '(' or a push is one step; every popped operator is one
//   step, so an operator or ')' that pops k entries takes k+1 steps and a
//   flush takes k+1 steps including the terminator. The engine's single
//   stack port and output register set this rate; the queue hides short bursts.
// Reset: clears the stack count, error flags and all valid flags. The
//   stack memory itself is not cleared; only live entries are ever used.
// Output stall: hold the result register; the engine halts on its next
//   emit, the queue fills and then in_stall_o rises.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  itp_pkg::sym_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output itp_pkg::sym_out_t out_data_o
);

  // Front to queue
  logic          fq_valid, fq_ready;
  itp_pkg::cmd_t fq_cmd;
  // Queue to stack engine
  logic          qb_valid, qb_ready;
  itp_pkg::cmd_t qb_cmd;

  // Classify each accepted request into a stack command
  itp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  // Buffer commands so intake keeps moving while the engine pops
  itp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_cmd),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_data_o  (qb_cmd)
  );

  // Run the operator stack and emit postfix results
  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### dv/tb_infix_to_postfix_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter_core: self-checking bench for the converter
// Streams infix characters and flush requests into the core while both
// channels idle at random, predicts the postfix stream in the bench, and
// compares every result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter_core;

  localparam int unsigned DEPTH        = 32;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 260;
  localparam int unsigned FINAL_ITEMS  = 50;
  localparam int unsigned DRAIN_CYCLES = 40;

  // Operand character ranges and other test characters
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ALL_ONE = 8'hFF;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  itp_pkg::sym_in_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  itp_pkg::sym_out_t out_data_o;

  // Bench-side copy of the converter state
  logic [7:0]        op_stack [DEPTH];
  int unsigned       op_depth  = 0;
  logic [1:0]        err_acc   = '0;
  itp_pkg::sym_out_t pending_postfix [$];

  int unsigned mismatch_cnt = 0;
  int unsigned sent_cnt     = 0;
  int unsigned cycle_cnt    = 0;
  bit          quiet        = 1'b0;
  bit          in_gap_on    = 1'b1;
  int unsigned stretch_left = 20;
  int unsigned hold_left    = 0;

  infix_to_postfix_converter_core #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic [1:0] op_rank(logic [7:0] c);
    case (c)
      itp_pkg::CH_CARET:                    return 2'd3;
      itp_pkg::CH_STAR, itp_pkg::CH_SLASH:  return 2'd2;
      itp_pkg::CH_PLUS, itp_pkg::CH_MINUS:  return 2'd1;
      default:                              return 2'd0;
    endcase
  endfunction

  function automatic bit is_alnum(logic [7:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           (c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
  endfunction

  function automatic void push_op(logic [7:0] c);
    if (op_depth < DEPTH) begin
      op_stack[op_depth] = c;
      op_depth++;
    end else begin
      err_acc[itp_pkg::ERR_OVERFLOW_BIT] = 1'b1;  // drop the character
    end
  endfunction

  // Work out the postfix results of one accepted request and queue them.
  function automatic void predict_postfix(logic [7:0] sym, logic flush);
    itp_pkg::sym_out_t batch [$];
    itp_pkg::sym_out_t r;
    logic [1:0]        p;
    r = '0;
    if (flush) begin
      while (op_depth > 0) begin
        op_depth--;
        r.out_symbol = op_stack[op_depth];
        batch.push_back(r);
      end
      r.out_symbol    = itp_pkg::CH_NUL;
      r.is_terminator = 1'b1;
      r.error_code    = err_acc;
      batch.push_back(r);
      err_acc = '0;
    end else if (is_alnum(sym)) begin
      r.out_symbol = sym;
      batch.push_back(r);
    end else if (sym == itp_pkg::CH_OPEN) begin
      push_op(sym);
    end else if (sym == itp_pkg::CH_CLOSE) begin
      while (op_depth > 0 && op_stack[op_depth-1] != itp_pkg::CH_OPEN) begin
        op_depth--;
        r.out_symbol = op_stack[op_depth];
        batch.push_back(r);
      end
      if (op_depth > 0) begin
        op_depth--;  // discard the matching '('
      end else begin
        err_acc[itp_pkg::ERR_UNMATCHED_BIT] = 1'b1;
      end
    end else begin
      // Rank zero pops everything, '(' included.
      p = op_rank(sym);
      while (op_depth > 0 && op_rank(op_stack[op_depth-1]) >= p) begin
        op_depth--;
        r.out_symbol = op_stack[op_depth];
        batch.push_back(r);
      end
      push_op(sym);
    end
    if (batch.size() > 0) begin
      batch[batch.size()-1].last = 1'b1;
    end
    foreach (batch[i]) begin
      pending_postfix.push_back(batch[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [7:0] sym, input logic flush);
    itp_pkg::sym_in_t req;
    req.symbol = sym;
    req.flush  = flush;
    // Insert an idle burst now and then, outside the calm stretches.
    if (!quiet && in_gap_on && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_postfix(sym, flush);
    sent_cnt++;
    stretch_left--;
    if (stretch_left == 0) begin
      in_gap_on    = 1'($urandom_range(0, 1));
      stretch_left = $urandom_range(10, 60);
    end
  endtask

  function automatic logic [7:0] pick_operand();
    int unsigned k;
    k = $urandom_range(0, 61);
    if (k < 26) return CH_LOWER_A + 8'(k);
    if (k < 52) return CH_UPPER_A + 8'(k - 26);
    return CH_DIGIT_0 + 8'(k - 52);
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 5))
      0:       return itp_pkg::CH_CARET;
      1:       return itp_pkg::CH_STAR;
      2:       return itp_pkg::CH_SLASH;
      3:       return itp_pkg::CH_PLUS;
      4:       return itp_pkg::CH_MINUS;
      default: return CH_PERCENT;  // rank-zero operator
    endcase
  endfunction

  // Build one expression with random content, optionally deep or corrupted,
  // send it and close it with a flush.
  task automatic send_expression(input bit deep, input bit broken);
    logic [7:0]  toks [$];
    int unsigned open_cnt;
    int unsigned terms;
    int unsigned pos;
    open_cnt = 0;
    terms    = $urandom_range(1, 8);
    if (deep) begin
      repeat ($urandom_range(DEPTH - 3, DEPTH + 3)) begin
        toks.push_back(itp_pkg::CH_OPEN);
        open_cnt++;
      end
    end
    for (int t = 0; t < terms; t++) begin
      while (open_cnt < 6 && $urandom_range(0, 3) == 0) begin
        toks.push_back(itp_pkg::CH_OPEN);
        open_cnt++;
      end
      toks.push_back(pick_operand());
      while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
        toks.push_back(itp_pkg::CH_CLOSE);
        open_cnt--;
      end
      if (t != terms - 1) toks.push_back(pick_operator());
    end
    repeat (open_cnt) toks.push_back(itp_pkg::CH_CLOSE);
    if (broken) begin
      pos = $urandom_range(0, toks.size());
      case ($urandom_range(0, 2))
        0:       toks.insert(pos, itp_pkg::CH_CLOSE);
        1:       toks.insert(pos, itp_pkg::CH_OPEN);
        default: toks.insert(pos, 8'($urandom_range(0, 255)));
      endcase
    end
    foreach (toks[i]) send_request(toks[i], 1'b0);
    send_request(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and output stall
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    itp_pkg::sym_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_postfix.size() == 0) begin
        $error("unexpected result out_symbol=%0h is_terminator=%0b error_code=%0d last=%0b",
               out_data_o.out_symbol, out_data_o.is_terminator,
               out_data_o.error_code, out_data_o.last);
        mismatch_cnt++;
      end else begin
        want = pending_postfix.pop_front();
        if (out_data_o.out_symbol !== want.out_symbol) begin
          $error("out_symbol: expected %0h, got %0h", want.out_symbol, out_data_o.out_symbol);
          mismatch_cnt++;
        end
        if (out_data_o.is_terminator !== want.is_terminator) begin
          $error("is_terminator: expected %0b, got %0b",
                 want.is_terminator, out_data_o.is_terminator);
          mismatch_cnt++;
        end
        if (out_data_o.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_data_o.error_code);
          mismatch_cnt++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data_o.last);
          mismatch_cnt++;
        end
      end
    end
  end

  // Stall bursts separated by free stretches, some long.
  always @(posedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      hold_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 20);
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      hold_left = $urandom_range(0, 14);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[infix_to_postfix_converter_core] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_operand_range();
    send_request(CH_LOWER_A, 1'b0);
    send_request(CH_LOWER_Z, 1'b0);
    send_request(CH_UPPER_A, 1'b0);
    send_request(CH_UPPER_Z, 1'b0);
    send_request(CH_DIGIT_0, 1'b0);
    send_request(CH_DIGIT_9, 1'b0);
  endtask

  // Each operator pops the one before it; '^' pops '^' (left-associative).
  task automatic test_operator_precedence();
    send_request(itp_pkg::CH_CARET, 1'b0);
    send_request(itp_pkg::CH_CARET, 1'b0);
    send_request(itp_pkg::CH_STAR, 1'b0);
    send_request(itp_pkg::CH_SLASH, 1'b0);
    send_request(itp_pkg::CH_PLUS, 1'b0);
    send_request(itp_pkg::CH_MINUS, 1'b0);
    send_request(itp_pkg::CH_NUL, 1'b1);
  endtask

  // Matched pair, then a close paren with nothing left to match.
  task automatic test_paren_matching();
    send_request(itp_pkg::CH_OPEN, 1'b0);
    send_request(itp_pkg::CH_PLUS, 1'b0);
    send_request(itp_pkg::CH_CLOSE, 1'b0);
    send_request(itp_pkg::CH_CLOSE, 1'b0);
    send_request(CH_ALL_ONE, 1'b1);
  endtask

  // Rank-zero characters flush the stack, '(' included; then flush twice.
  task automatic test_rank_zero_symbols();
    send_request(itp_pkg::CH_OPEN, 1'b0);
    send_request(itp_pkg::CH_STAR, 1'b0);
    send_request(itp_pkg::CH_NUL, 1'b0);
    send_request(CH_ALL_ONE, 1'b0);
    send_request(CH_ALL_ONE, 1'b1);
    send_request(itp_pkg::CH_NUL, 1'b1);
  endtask

  // Overrun the stack, alone and together with an unmatched close paren.
  task automatic test_stack_overflow();
    repeat (DEPTH + 1) send_request(itp_pkg::CH_OPEN, 1'b0);
    repeat (DEPTH + 1) send_request(itp_pkg::CH_CLOSE, 1'b0);
    send_request(itp_pkg::CH_NUL, 1'b1);
    repeat (DEPTH + 2) send_request(itp_pkg::CH_OPEN, 1'b0);
    send_request(itp_pkg::CH_NUL, 1'b1);
  endtask

  task automatic test_random_expressions(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    target = sent_cnt + count;
    while (sent_cnt < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_expression(1'b0, 1'b0);
      end else if (pick < 82) begin
        send_expression(1'b0, 1'b1);
      end else if (pick < 86) begin
        send_expression(1'b1, 1'($urandom_range(0, 1)));
      end else begin
        // Raw bytes with the odd flush mixed in.
        repeat ($urandom_range(1, 8)) begin
          send_request(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_operand_range();
    test_operator_precedence();
    test_paren_matching();
    test_rank_zero_symbols();
    test_stack_overflow();
    test_random_expressions(RANDOM_ITEMS);
    quiet = 1'b1;
    test_random_expressions(FINAL_ITEMS);
    send_request(itp_pkg::CH_NUL, 1'b1);

    // Drop valid and wait for the last results to come back.
    in_valid_i <= 1'b0;
    while (pending_postfix.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_postfix.size() == 0) begin
      $display("[infix_to_postfix_converter_core] OK");
    end else begin
      $display("[infix_to_postfix_converter_core] ERROR");
    end
    $finish;
  end

endmodule
